/* src/induced_five_path_counter_assert.svh */
// Assertion macros for the induced five-path counter checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef INDUCED_FIVE_PATH_COUNTER_ASSERT_SVH
`define INDUCED_FIVE_PATH_COUNTER_ASSERT_SVH

// Same-cycle implication
`define IFPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IFPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ifpc_pkg.sv */
`default_nettype none

package ifpc_pkg;

  // Fixed geometry
  localparam int MAX_VERTICES = 16;
  localparam int VW           = 4;   // vertex index width
  localparam int ROW_W        = 16;  // adjacency row width
  localparam int CNT_W        = 5;   // vertex_count width
  localparam int POP_W        = 5;   // population count of one row
  localparam int TOTAL_W      = 32;  // path_count width
  localparam int STEP_W       = 4;   // microcode step counter
  localparam int ACT_W        = 4;
  localparam int COND_W       = 3;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [VW-1:0]    vidx_t;

  // Datapath actions
  localparam logic [ACT_W-1:0] A_IDLE   = 4'd0;
  localparam logic [ACT_W-1:0] A_INIT   = 4'd1;
  localparam logic [ACT_W-1:0] A_U_READ = 4'd2;
  localparam logic [ACT_W-1:0] A_U_LOAD = 4'd3;
  localparam logic [ACT_W-1:0] A_V_PICK = 4'd4;
  localparam logic [ACT_W-1:0] A_V_LOAD = 4'd5;
  localparam logic [ACT_W-1:0] A_W_PICK = 4'd6;
  localparam logic [ACT_W-1:0] A_W_LOAD = 4'd7;
  localparam logic [ACT_W-1:0] A_X_PICK = 4'd8;
  localparam logic [ACT_W-1:0] A_X_LOAD = 4'd9;
  localparam logic [ACT_W-1:0] A_ACC    = 4'd10;
  localparam logic [ACT_W-1:0] A_U_NEXT = 4'd11;
  localparam logic [ACT_W-1:0] A_DONE   = 4'd12;

  // Jump conditions
  localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS  = 3'd1;
  localparam logic [COND_W-1:0] C_U_END   = 3'd2;
  localparam logic [COND_W-1:0] C_VS_ZERO = 3'd3;
  localparam logic [COND_W-1:0] C_WS_ZERO = 3'd4;
  localparam logic [COND_W-1:0] C_W_SKIP  = 3'd5;
  localparam logic [COND_W-1:0] C_XS_ZERO = 3'd6;
  localparam logic [COND_W-1:0] C_X_SKIP  = 3'd7;

  // Program steps
  localparam logic [STEP_W-1:0] S_INIT   = 4'd0;
  localparam logic [STEP_W-1:0] S_U_TOP  = 4'd1;
  localparam logic [STEP_W-1:0] S_U_LOAD = 4'd2;
  localparam logic [STEP_W-1:0] S_V_TOP  = 4'd3;
  localparam logic [STEP_W-1:0] S_V_LOAD = 4'd4;
  localparam logic [STEP_W-1:0] S_W_TOP  = 4'd5;
  localparam logic [STEP_W-1:0] S_W_LOAD = 4'd6;
  localparam logic [STEP_W-1:0] S_X_TOP  = 4'd7;
  localparam logic [STEP_W-1:0] S_X_LOAD = 4'd8;
  localparam logic [STEP_W-1:0] S_ACC    = 4'd9;
  localparam logic [STEP_W-1:0] S_U_NEXT = 4'd10;
  localparam logic [STEP_W-1:0] S_DONE   = 4'd11;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic [ACT_W-1:0] act;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic u_end;
    logic vs_zero;
    logic ws_zero;
    logic w_skip;
    logic xs_zero;
    logic x_skip;
  } stat_t;

  // Microcode ROM: the four nested walks over u, v, w, x
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t uw;
    unique case (step)
      S_INIT:   uw = '{act: A_INIT,   cond: C_NEXT,    target: S_INIT};
      S_U_TOP:  uw = '{act: A_U_READ, cond: C_U_END,   target: S_DONE};
      S_U_LOAD: uw = '{act: A_U_LOAD, cond: C_NEXT,    target: S_INIT};
      S_V_TOP:  uw = '{act: A_V_PICK, cond: C_VS_ZERO, target: S_U_NEXT};
      S_V_LOAD: uw = '{act: A_V_LOAD, cond: C_NEXT,    target: S_INIT};
      S_W_TOP:  uw = '{act: A_W_PICK, cond: C_WS_ZERO, target: S_V_TOP};
      S_W_LOAD: uw = '{act: A_W_LOAD, cond: C_W_SKIP,  target: S_W_TOP};
      S_X_TOP:  uw = '{act: A_X_PICK, cond: C_XS_ZERO, target: S_W_TOP};
      S_X_LOAD: uw = '{act: A_X_LOAD, cond: C_X_SKIP,  target: S_X_TOP};
      S_ACC:    uw = '{act: A_ACC,    cond: C_ALWAYS,  target: S_X_TOP};
      S_U_NEXT: uw = '{act: A_U_NEXT, cond: C_ALWAYS,  target: S_U_TOP};
      S_DONE:   uw = '{act: A_DONE,   cond: C_ALWAYS,  target: S_DONE};
      default:  uw = '{act: A_DONE,   cond: C_ALWAYS,  target: S_DONE};
    endcase
    return uw;
  endfunction

  // Index of the lowest set bit (zero for an empty mask)
  function automatic vidx_t lowest_bit(input row_t m);
    vidx_t r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (m[i]) r = vidx_t'(i);
    end
    return r;
  endfunction

  // Adder-tree population count of one row
  function automatic logic [POP_W-1:0] pop_count(input row_t m);
    logic [1:0] s2 [8];
    logic [2:0] s4 [4];
    logic [3:0] s8 [2];
    for (int i = 0; i < 8; i++) s2[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
    for (int i = 0; i < 4; i++) s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 2; i++) s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s8[0]} + {1'b0, s8[1]};
  endfunction

endpackage

`default_nettype wire

/* src/ifpc_if.sv */
`default_nettype none

// Command channel: row loads and count requests
interface ifpc_cmd_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [3:0]           row_index;
  logic [15:0]          row_bits;
  modport source (output valid, op, row_index, row_bits, input ready);
  modport sink   (input valid, op, row_index, row_bits, output ready);
endinterface

// Result channel
interface ifpc_result_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          path_count;
  modport source (output valid, path_count, input ready);
  modport sink   (input valid, path_count, output ready);
endinterface

// Configuration write channel
interface ifpc_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [4:0]           vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

/* src/ifpc_seq.sv */
`default_nettype none

module ifpc_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  input  ifpc_pkg::stat_t   stat,
  output ifpc_pkg::ctrl_t   ctrl,
  output logic              busy,
  output logic              done_fire
);

  logic [ifpc_pkg::STEP_W-1:0] step;
  logic [ifpc_pkg::STEP_W-1:0] step_next;
  ifpc_pkg::uword_t            uw;
  logic                        jump;

  // Control word fetch
  assign uw = ifpc_pkg::ucode(step);

  // Condition select
  always_comb begin
    unique case (uw.cond)
      ifpc_pkg::C_NEXT:    jump = 1'b0;
      ifpc_pkg::C_ALWAYS:  jump = 1'b1;
      ifpc_pkg::C_U_END:   jump = stat.u_end;
      ifpc_pkg::C_VS_ZERO: jump = stat.vs_zero;
      ifpc_pkg::C_WS_ZERO: jump = stat.ws_zero;
      ifpc_pkg::C_W_SKIP:  jump = stat.w_skip;
      ifpc_pkg::C_XS_ZERO: jump = stat.xs_zero;
      ifpc_pkg::C_X_SKIP:  jump = stat.x_skip;
    endcase
  end

  assign step_next = jump ? uw.target : step + ifpc_pkg::STEP_W'(1);
  assign ctrl.act  = busy ? uw.act : ifpc_pkg::A_IDLE;
  assign done_fire = busy && (uw.act == ifpc_pkg::A_DONE) && out_free;

  // Step counter and run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ifpc_pkg::S_INIT;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= ifpc_pkg::S_INIT;
      end
    end else if (done_fire) begin
      busy <= 1'b0;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* src/ifpc_dp.sv */
`default_nettype none

module ifpc_dp (
  input  logic                          clk,
  input  logic                          load,
  input  ifpc_pkg::vidx_t               load_index,
  input  ifpc_pkg::row_t                load_bits,
  input  logic [ifpc_pkg::CNT_W-1:0]    vertex_count,
  input  ifpc_pkg::ctrl_t               ctrl,
  output ifpc_pkg::stat_t               stat,
  output logic [ifpc_pkg::TOTAL_W-1:0]  total
);

  // Row store for the walk, plus a flop copy read column-wise
  ifpc_pkg::row_t              mem [ifpc_pkg::MAX_VERTICES];
  ifpc_pkg::row_t              adj [ifpc_pkg::MAX_VERTICES];
  ifpc_pkg::row_t              rd;
  ifpc_pkg::row_t              rdm;

  logic [ifpc_pkg::CNT_W-1:0]  n;
  logic [ifpc_pkg::CNT_W-1:0]  u;
  ifpc_pkg::vidx_t             v;
  ifpc_pkg::vidx_t             w;
  ifpc_pkg::row_t              vs;
  ifpc_pkg::row_t              ws;
  ifpc_pkg::row_t              xs;
  ifpc_pkg::row_t              fu;
  ifpc_pkg::row_t              fuv;
  ifpc_pkg::row_t              fuvw;
  logic [ifpc_pkg::POP_W-1:0]  cnt;

  ifpc_pkg::row_t              live;
  ifpc_pkg::row_t              at_least_u;
  ifpc_pkg::row_t              col_raw;
  ifpc_pkg::row_t              col_live;
  ifpc_pkg::vidx_t             lo_vs;
  ifpc_pkg::vidx_t             lo_ws;
  ifpc_pkg::vidx_t             lo_xs;
  ifpc_pkg::vidx_t             raddr;
  ifpc_pkg::vidx_t             csel;
  logic [ifpc_pkg::TOTAL_W:0]  sum;

  // Vertices in use and the masks derived from it
  assign n = (vertex_count > ifpc_pkg::CNT_W'(ifpc_pkg::MAX_VERTICES))
             ? ifpc_pkg::CNT_W'(ifpc_pkg::MAX_VERTICES) : vertex_count;
  assign live = (n == ifpc_pkg::CNT_W'(ifpc_pkg::ROW_W)) ? '1
              : ((ifpc_pkg::row_t'(1) << n[ifpc_pkg::VW-1:0]) - ifpc_pkg::row_t'(1));
  assign at_least_u = live
              & ~((ifpc_pkg::row_t'(1) << u[ifpc_pkg::VW-1:0]) - ifpc_pkg::row_t'(1));
  assign rdm = rd & live;

  assign lo_vs = ifpc_pkg::lowest_bit(vs);
  assign lo_ws = ifpc_pkg::lowest_bit(ws);
  assign lo_xs = ifpc_pkg::lowest_bit(xs);

  // Read address and column select per action
  always_comb begin
    raddr = '0;
    csel  = '0;
    unique case (ctrl.act)
      ifpc_pkg::A_U_READ: begin
        raddr = u[ifpc_pkg::VW-1:0];
        csel  = u[ifpc_pkg::VW-1:0];
      end
      ifpc_pkg::A_V_PICK: begin
        raddr = lo_vs;
        csel  = lo_vs;
      end
      ifpc_pkg::A_W_PICK: begin
        raddr = lo_ws;
        csel  = lo_ws;
      end
      ifpc_pkg::A_X_PICK: raddr = lo_xs;
      default: ;
    endcase
  end

  // Column k: which rows have bit k set
  always_comb begin
    for (int a = 0; a < ifpc_pkg::MAX_VERTICES; a++) begin
      col_raw[a] = adj[a][csel];
    end
  end
  assign col_live = col_raw & live;

  // Row loads, registered read
  always_ff @(posedge clk) begin
    if (load) begin
      mem[load_index] <= load_bits;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < ifpc_pkg::MAX_VERTICES; a++) begin
      if (load && (load_index == ifpc_pkg::vidx_t'(a))) adj[a] <= load_bits;
    end
  end

  // Saturating accumulate
  assign sum = {1'b0, total} + (ifpc_pkg::TOTAL_W + 1)'(cnt);

  // Walk registers
  always_ff @(posedge clk) begin
    unique case (ctrl.act)
      ifpc_pkg::A_INIT: begin
        u     <= '0;
        total <= '0;
      end
      ifpc_pkg::A_U_READ: fu <= col_live;
      ifpc_pkg::A_U_LOAD: vs <= rdm;
      ifpc_pkg::A_V_PICK: begin
        v   <= lo_vs;
        vs  <= vs & (vs - ifpc_pkg::row_t'(1));
        fuv <= fu | col_live;
      end
      ifpc_pkg::A_V_LOAD: ws <= rdm;
      ifpc_pkg::A_W_PICK: begin
        w    <= lo_ws;
        ws   <= ws & (ws - ifpc_pkg::row_t'(1));
        fuvw <= fuv | col_live;
      end
      ifpc_pkg::A_W_LOAD: xs <= rdm;
      ifpc_pkg::A_X_PICK: xs <= xs & (xs - ifpc_pkg::row_t'(1));
      ifpc_pkg::A_X_LOAD: cnt <= ifpc_pkg::pop_count(rdm & at_least_u & ~fuvw);
      ifpc_pkg::A_ACC:
        total <= sum[ifpc_pkg::TOTAL_W] ? '1 : sum[ifpc_pkg::TOTAL_W-1:0];
      ifpc_pkg::A_U_NEXT: u <= u + ifpc_pkg::CNT_W'(1);
      default: ;
    endcase
  end

  // Status for the sequencer
  assign stat.u_end   = (u >= n);
  assign stat.vs_zero = (vs == '0);
  assign stat.ws_zero = (ws == '0);
  assign stat.w_skip  = (w == u[ifpc_pkg::VW-1:0]) || rdm[u[ifpc_pkg::VW-1:0]];
  assign stat.xs_zero = (xs == '0);
  assign stat.x_skip  = rdm[v] || rdm[u[ifpc_pkg::VW-1:0]];

endmodule

`default_nettype wire

/* src/induced_five_path_counter.sv */
// Row load (op 0): no result; loads are taken back to back while idle.
// Count (op 1): walks each vertex u, each neighbour v of u, each neighbour w of v that
//   passes the u check, and each neighbour x of w tried; each x kept adds to the total.
//   Every step reads one row from the row store.
// One count at a time; the next command is taken as soon as the result is registered.
// Reset (synchronous, rst high): sequencer idle, no result pending, vertex_count = 16;
//   adjacency rows are undefined until loaded.
`default_nettype none

module induced_five_path_counter (
  input  logic                  clk,
  input  logic                  rst,
  ifpc_cmd_if.sink              cmd,
  ifpc_result_if.source         result,
  ifpc_cfg_if.sink              cfg
);

  logic [ifpc_pkg::CNT_W-1:0]   vertex_count;
  logic [ifpc_pkg::TOTAL_W-1:0] total;
  ifpc_pkg::ctrl_t              ctrl;
  ifpc_pkg::stat_t              stat;
  logic                         busy;
  logic                         done_fire;
  logic                         start;
  logic                         load;
  logic                         out_free;
  logic                         result_valid;
  logic [ifpc_pkg::TOTAL_W-1:0] path_count;

  // Command decode
  assign cmd.ready = !busy;
  assign start     = cmd.valid && cmd.ready && cmd.op;
  assign load      = cmd.valid && cmd.ready && !cmd.op;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= ifpc_pkg::CNT_W'(ifpc_pkg::MAX_VERTICES);
    end else if (cfg.valid && cfg.ready) begin
      vertex_count <= cfg.vertex_count;
    end
  end

  ifpc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .out_free  (out_free),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .done_fire (done_fire)
  );

  ifpc_dp u_dp (
    .clk          (clk),
    .load         (load),
    .load_index   (cmd.row_index),
    .load_bits    (cmd.row_bits),
    .vertex_count (vertex_count),
    .ctrl         (ctrl),
    .stat         (stat),
    .total        (total)
  );

  // Output register
  assign out_free = !result_valid || result.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_fire) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) path_count <= total;
  end

  assign result.valid      = result_valid;
  assign result.path_count = path_count;

endmodule

`default_nettype wire

/* src/ifpc_chk.sv */
`default_nettype none

`include "induced_five_path_counter_assert.svh"

module ifpc_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        cmd_op,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] path_count
);

  // A count occupies the block
  `IFPC_ASSERT_NXT(a_count_busy, cmd_valid && cmd_ready && cmd_op, !cmd_ready, "count did not hold off commands")

  // A row load never occupies the block
  `IFPC_ASSERT_NXT(a_load_free, cmd_valid && cmd_ready && !cmd_op, cmd_ready, "row load blocked commands")

  // A new result means the count has finished
  `IFPC_ASSERT_IMP(a_result_frees, $rose(result_valid), cmd_ready, "result shown while still counting")

  // Pending result holds its value
  `IFPC_ASSERT_NXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(path_count), "stalled result changed")

endmodule

bind induced_five_path_counter ifpc_chk u_ifpc_chk (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_op       (cmd.op),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .path_count   (result.path_count)
);

`default_nettype wire

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOAD_ROW = 1'b0;
  localparam logic OP_COUNT    = 1'b1;

  localparam int IDLE_PCT      = 20;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic            op;
    ifpc_pkg::vidx_t row_index;
    ifpc_pkg::row_t  row_bits;
  } graph_cmd_t;

  logic clk = 1'b0;
  logic rst;

  ifpc_cmd_if    cmd_ch();
  ifpc_result_if result_ch();
  ifpc_cfg_if    cfg_ch();

  induced_five_path_counter i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #4 clk = ~clk;

  // Shadow of the block's graph store and vertex count
  ifpc_pkg::row_t adj_rows [ifpc_pkg::MAX_VERTICES];
  logic [4:0]     vtx_count;

  graph_cmd_t  pending_cmds [$];
  logic [31:0] expected_counts [$];
  int unsigned mismatch_count = 0;

  // Both sides stop idling while this is set
  logic        steady;

  graph_cmd_t  next_cmd;
  logic [31:0] want_count;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Induced P5 count over the shadow store; y >= u keeps one direction per path
  function automatic logic [31:0] count_induced_p5();
    ifpc_pkg::row_t  r [ifpc_pkg::MAX_VERTICES];
    ifpc_pkg::row_t  c [ifpc_pkg::MAX_VERTICES];
    ifpc_pkg::row_t  live;
    ifpc_pkg::row_t  from_u;
    ifpc_pkg::row_t  ys;
    longint unsigned total;
    int              n;
    n = (vtx_count > ifpc_pkg::MAX_VERTICES) ? ifpc_pkg::MAX_VERTICES : int'(vtx_count);
    live = ifpc_pkg::row_t'((17'd1 << n) - 17'd1);
    total = 0;
    for (int a = 0; a < ifpc_pkg::MAX_VERTICES; a++) begin
      r[a] = (a < n) ? (adj_rows[a] & live) : '0;
      c[a] = '0;
    end
    // column masks: who points at b
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (r[a][b]) c[b][a] = 1'b1;
    for (int u = 0; u < n; u++) begin
      from_u = live & ~ifpc_pkg::row_t'((17'd1 << u) - 17'd1);
      for (int v = 0; v < n; v++) begin
        if (!r[u][v]) continue;
        for (int w = 0; w < n; w++) begin
          if (!r[v][w] || w == u || r[w][u]) continue;
          for (int x = 0; x < n; x++) begin
            if (!r[w][x] || r[x][v] || r[x][u]) continue;
            ys = r[x] & from_u & ~c[w] & ~c[v] & ~c[u];
            total += $countones(ys);
          end
        end
      end
    end
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic ifpc_pkg::row_t random_row();
    ifpc_pkg::row_t a, b, c;
    a = ifpc_pkg::row_t'($urandom);
    b = ifpc_pkg::row_t'($urandom);
    c = ifpc_pkg::row_t'($urandom);
    case ($urandom_range(3))
      0:       return a & b & c;
      1:       return a & b;
      2:       return a;
      default: return a | b;
    endcase
  endfunction

  task automatic push_load(input int idx, input ifpc_pkg::row_t bits);
    pending_cmds.push_back(graph_cmd_t'{op: OP_LOAD_ROW,
                                        row_index: ifpc_pkg::vidx_t'(idx),
                                        row_bits: bits});
  endtask

  task automatic push_count();
    pending_cmds.push_back(graph_cmd_t'{op: OP_COUNT,
                                        row_index: ifpc_pkg::vidx_t'($urandom),
                                        row_bits: ifpc_pkg::row_t'($urandom)});
  endtask

  // Block is idle once everything is sent and answered, plus a SETTLE_CYCLES wait for a last load;
  // sampled at the falling edge so that the rising edge's updates have all settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_counts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_cmd = pending_cmds.pop_front();
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= next_cmd.op;
        cmd_ch.row_index <= next_cmd.row_index;
        cmd_ch.row_bits  <= next_cmd.row_bits;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Command monitor: update the shadow store, predict a count per count transaction
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      if (cmd_ch.op == OP_LOAD_ROW) begin
        if (cmd_ch.row_index < ifpc_pkg::MAX_VERTICES)
          adj_rows[cmd_ch.row_index] = cmd_ch.row_bits;
      end else begin
        expected_counts.push_back(count_induced_p5());
      end
    end
  end

  // Result receiver: random stalls, one long hold-off after the first count goes in
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!hold_done && cmd_ch.valid && cmd_ch.ready && cmd_ch.op == OP_COUNT) begin
      hold_done       <= 1'b1;
      hold_left       <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_counts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("path_count %0d with no count outstanding", result_ch.path_count);
      end else begin
        want_count = expected_counts.pop_front();
        if (result_ch.path_count !== want_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("path_count: expected %0d, got %0d", want_count, result_ch.path_count);
        end
      end
    end
  end

  // Stimulus
  initial begin
    ifpc_pkg::row_t g [ifpc_pkg::MAX_VERTICES];
    logic [4:0]     phase_counts [10];
    ifpc_pkg::row_t live;
    int             n;
    int             pct;
    int             a;
    int             b;

    cmd_ch.valid        = 1'b0;
    cmd_ch.op           = OP_LOAD_ROW;
    cmd_ch.row_index    = '0;
    cmd_ch.row_bits     = '0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.vertex_count = '0;
    steady              = 1'b0;
    rst                 = 1'b1;
    vtx_count           = 5'd16;
    for (int i = 0; i < ifpc_pkg::MAX_VERTICES; i++) adj_rows[i] = '0;
    phase_counts = '{5'd0, 5'd1, 5'd5, 5'd31, 5'd4, 5'd6, 5'd3, 5'd8, 5'd2, 5'd16};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed graph: every row written once so no count reads an empty slot
    for (int i = 0; i < ifpc_pkg::MAX_VERTICES; i++) g[i] = '0;
    // induced path 0-1-2-3-4
    for (int i = 0; i < 4; i++) begin
      g[i][i+1] = 1'b1;
      g[i+1][i] = 1'b1;
    end
    // five-vertex ring on 5..9: no induced P5 inside
    for (int i = 0; i < 5; i++) begin
      a = 5 + i;
      b = 5 + (i + 1) % 5;
      g[a][b] = 1'b1;
      g[b][a] = 1'b1;
    end
    // short path 10..13, then a one-way edge to an empty row
    for (int i = 10; i < 13; i++) begin
      g[i][i+1] = 1'b1;
      g[i+1][i] = 1'b1;
    end
    g[13][14] = 1'b1;
    // all ones: self loop and unmirrored bits
    g[15] = '1;
    for (int i = 0; i < ifpc_pkg::MAX_VERTICES; i++) push_load(i, g[i]);
    push_count();
    push_load(0, '1);
    push_load(15, '0);
    push_count();
    push_load(15, 16'h8000);
    push_count();
    wait_drained();

    // Random phases, one vertex count each
    foreach (phase_counts[p]) begin
      @(posedge clk);
      cfg_ch.valid        <= 1'b1;
      cfg_ch.vertex_count <= phase_counts[p];
      do @(posedge clk);
      while (!cfg_ch.ready);
      vtx_count = phase_counts[p];
      cfg_ch.valid <= 1'b0;
      steady <= (p == 4 || p == 5);

      n = (phase_counts[p] > ifpc_pkg::MAX_VERTICES) ? ifpc_pkg::MAX_VERTICES
                                                      : int'(phase_counts[p]);
      live = ifpc_pkg::row_t'((17'd1 << n) - 17'd1);
      for (int s = 0; s < 3; s++) begin
        if ($urandom_range(3) == 0) begin
          // fresh undirected graph on the live vertices, junk above them
          pct = $urandom_range(10, 70);
          for (int i = 0; i < ifpc_pkg::MAX_VERTICES; i++) g[i] = '0;
          for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++)
              if ($urandom_range(99) < pct) begin
                g[i][j] = 1'b1;
                g[j][i] = 1'b1;
              end
          for (int i = 0; i < n; i++) push_load(i, g[i] | (random_row() & ~live));
        end else begin
          // raw rewrites, taken literally by the block
          repeat ($urandom_range(3))
            push_load($urandom_range(ifpc_pkg::MAX_VERTICES - 1), random_row());
        end
        push_count();
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
